// File: design/mat_pkg.sv
// Shared types, codes and constants for the multi-alarm tick timer.
`timescale 1ns / 1ps
`default_nettype none
package mat_pkg;

  localparam int SLOT_CAP           = 4;
  localparam int SLOT_W             = 2;
  localparam int DESC_W             = 36;
  localparam int CNT_W              = 16;
  localparam int ID_W               = 8;
  localparam int TASK_W             = 8;
  localparam int DEF_NUM_ALARMS     = 4;
  localparam int DEF_TICK_PERIOD_MS = 1;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic [1:0] ACT_TASK     = 2'd0;
  localparam logic [1:0] ACT_CALLBACK = 2'd1;

  localparam logic [2:0] KIND_TASK       = 3'd0;
  localparam logic [2:0] KIND_CALLBACK   = 3'd1;
  localparam logic [2:0] KIND_MISSING_CB = 3'd2;
  localparam logic [2:0] KIND_NO_ACTION  = 3'd3;
  localparam logic [2:0] KIND_DONE       = 3'd4;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_UNKNOWN_ID = 2'd1;
  localparam logic [1:0] STAT_WRONG_TRAN = 2'd2;
  localparam logic [1:0] STAT_MISSING_CB = 2'd3;

  // Descriptor layout, msb first.
  typedef struct packed {
    logic              cb_present;
    logic [TASK_W-1:0] task_id;
    logic [1:0]        action;
    logic              oneshot;
    logic [CNT_W-1:0]  timeout_ms;
    logic [ID_W-1:0]   id;
  } desc_t;

  // One result word.
  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [TASK_W-1:0] task_id;
    logic [1:0]        status;
    logic              last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_SCAN,
    ST_CLOSE
  } state_t;

endpackage
`default_nettype wire

// File: design/mat_eval.sv
// Shared slot evaluation unit: registered (count+2)*period product and fire compare.
`timescale 1ns / 1ps
`default_nettype none
module mat_eval #(
  parameter int TICK_PERIOD_MS = mat_pkg::DEF_TICK_PERIOD_MS
) (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic [mat_pkg::CNT_W-1:0]  count,
  input  wire logic [mat_pkg::SLOT_W-1:0] slot,
  input  wire mat_pkg::desc_t             desc,
  output logic [mat_pkg::CNT_W-1:0]       count_inc,
  output logic                            fire,
  output mat_pkg::res_t                   res
);

  localparam int PER_W  = $clog2(TICK_PERIOD_MS + 1);
  localparam int PROD_W = mat_pkg::CNT_W + 1 + PER_W;

  logic [PROD_W-1:0]       prod;
  logic [mat_pkg::CNT_W:0] inc_plus1;

  // count+1 >= floor(t/P)  <=>  (count+2)*P > t
  assign inc_plus1 = {1'b0, count} + (mat_pkg::CNT_W+1)'(2);

  always_ff @(posedge clk) begin
    if (load) begin
      count_inc <= count + mat_pkg::CNT_W'(1);
      prod      <= PROD_W'(inc_plus1) * PROD_W'(TICK_PERIOD_MS);
    end
  end

  // A stored count is always below a threshold of at most 0xFFFF, so it never
  // holds all ones and count+1 never wraps.
  assign fire = prod > PROD_W'(desc.timeout_ms);

  always_comb begin
    res      = '0;
    res.slot = slot;
    res.last = 1'b0;
    unique case (desc.action)
      mat_pkg::ACT_TASK: begin
        res.kind    = mat_pkg::KIND_TASK;
        res.task_id = desc.task_id;
        res.status  = mat_pkg::STAT_OK;
      end
      mat_pkg::ACT_CALLBACK: begin
        if (desc.cb_present) begin
          res.kind   = mat_pkg::KIND_CALLBACK;
          res.status = mat_pkg::STAT_OK;
        end else begin
          res.kind   = mat_pkg::KIND_MISSING_CB;
          res.status = mat_pkg::STAT_MISSING_CB;
        end
      end
      default: begin
        res.kind   = mat_pkg::KIND_NO_ACTION;
        res.status = mat_pkg::STAT_OK;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/multi_alarm_tick_timer.sv
// Top level of the multi-alarm tick timer: slot state, sequencer and result port.
`timescale 1ns / 1ps
`default_nettype none
// A bank of NUM_ALARMS alarm slots, each described by a 36-bit descriptor
// register (id, timeout in ms, one-shot, action, task, callback present).
// A command word is taken when start is high and busy is low. A tick walks
// the slots one at a time through a single shared unit that multiplies the
// slot's counter plus two by TICK_PERIOD_MS and compares it with the
// timeout: an idle slot takes only the load state, an active slot the load
// state (product register) and then the eval state (compare and writeback),
// and a closing state follows; busy stays high throughout. Start and stop
// scan the ids one slot per cycle and stop at the first match or the last
// slot; an unused command code goes straight to the closing state. Every
// result word is shown on the output ports for exactly one cycle with valid
// high, in the cycle after the step that made it; the receiver has no way
// to stall it, so it must take each word as it comes. The final word of a
// command has last set. Descriptor writes are meant for idle periods only.
module multi_alarm_tick_timer #(
  parameter int NUM_ALARMS     = mat_pkg::DEF_NUM_ALARMS,
  parameter int TICK_PERIOD_MS = mat_pkg::DEF_TICK_PERIOD_MS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  command,
  input  wire logic [mat_pkg::ID_W-1:0]    alarm_id,
  input  wire logic                        cfg_write,
  input  wire logic [mat_pkg::SLOT_W-1:0]  cfg_index,
  input  wire logic [mat_pkg::DESC_W-1:0]  cfg_data,
  output logic                             valid,
  output logic [2:0]                       event_kind,
  output logic [mat_pkg::SLOT_W-1:0]       slot_index,
  output logic [mat_pkg::TASK_W-1:0]       task_number,
  output logic [1:0]                       status,
  output logic                             last
);

  localparam logic [mat_pkg::SLOT_W-1:0] LAST_SLOT = mat_pkg::SLOT_W'(NUM_ALARMS - 1);

  mat_pkg::state_t state, state_next;
  logic [mat_pkg::SLOT_W-1:0] slot, slot_next;
  logic [1:0]                 cmd;
  logic [mat_pkg::ID_W-1:0]   id;

  mat_pkg::desc_t             desc   [mat_pkg::SLOT_CAP];
  logic                       active [mat_pkg::SLOT_CAP];
  logic [mat_pkg::CNT_W-1:0]  counter[mat_pkg::SLOT_CAP];

  mat_pkg::desc_t             cur_desc;
  logic                       cur_active;
  logic                       at_last;
  logic                       id_match;
  logic                       accept;

  // shared unit
  logic                       unit_load;
  logic [mat_pkg::CNT_W-1:0]  count_inc;
  logic                       fire;
  mat_pkg::res_t              fire_res;

  // sequencer outputs
  logic                       emit;
  mat_pkg::res_t              emit_res;
  logic                       cnt_we;
  logic [mat_pkg::CNT_W-1:0]  cnt_wdata;
  logic                       act_we;
  logic                       act_wdata;

  assign cur_desc   = desc[slot];
  assign cur_active = active[slot];
  assign at_last    = slot == LAST_SLOT;
  assign id_match   = cur_desc.id == id;
  assign busy       = state != mat_pkg::ST_IDLE;
  assign accept     = start && !busy;

  mat_eval #(
    .TICK_PERIOD_MS(TICK_PERIOD_MS)
  ) u_eval (
    .clk      (clk),
    .load     (unit_load),
    .count    (counter[slot]),
    .slot     (slot),
    .desc     (cur_desc),
    .count_inc(count_inc),
    .fire     (fire),
    .res      (fire_res)
  );

  // next state and slot pointer
  always_comb begin
    state_next = state;
    slot_next  = slot;
    unique case (state)
      mat_pkg::ST_IDLE: begin
        if (accept) begin
          slot_next = '0;
          if (command == mat_pkg::CMD_TICK) begin
            state_next = mat_pkg::ST_LOAD;
          end else if (command == mat_pkg::CMD_START || command == mat_pkg::CMD_STOP) begin
            state_next = mat_pkg::ST_SCAN;
          end else begin
            state_next = mat_pkg::ST_CLOSE;
          end
        end
      end
      mat_pkg::ST_LOAD: begin
        if (cur_active) begin
          state_next = mat_pkg::ST_EVAL;
        end else if (at_last) begin
          state_next = mat_pkg::ST_CLOSE;
        end else begin
          slot_next = slot + mat_pkg::SLOT_W'(1);
        end
      end
      mat_pkg::ST_EVAL: begin
        if (at_last) begin
          state_next = mat_pkg::ST_CLOSE;
        end else begin
          state_next = mat_pkg::ST_LOAD;
          slot_next  = slot + mat_pkg::SLOT_W'(1);
        end
      end
      mat_pkg::ST_SCAN: begin
        if (id_match || at_last) begin
          state_next = mat_pkg::ST_IDLE;
        end else begin
          slot_next = slot + mat_pkg::SLOT_W'(1);
        end
      end
      mat_pkg::ST_CLOSE: begin
        state_next = mat_pkg::ST_IDLE;
      end
      default: begin
        state_next = mat_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath controls and result words
  always_comb begin
    unit_load = 1'b0;
    emit      = 1'b0;
    emit_res  = '0;
    cnt_we    = 1'b0;
    cnt_wdata = count_inc;
    act_we    = 1'b0;
    act_wdata = 1'b0;
    unique case (state)
      mat_pkg::ST_LOAD: begin
        unit_load = cur_active;
      end
      mat_pkg::ST_EVAL: begin
        cnt_we = 1'b1;
        if (fire) begin
          cnt_wdata = '0;
          emit      = 1'b1;
          emit_res  = fire_res;
          act_we    = cur_desc.oneshot;
          act_wdata = 1'b0;
        end
      end
      mat_pkg::ST_SCAN: begin
        emit_res.kind = mat_pkg::KIND_DONE;
        emit_res.last = 1'b1;
        if (id_match) begin
          emit          = 1'b1;
          emit_res.slot = slot;
          // start wants an idle slot, stop an active one
          if (cur_active == (cmd == mat_pkg::CMD_STOP)) begin
            emit_res.status = mat_pkg::STAT_OK;
            act_we          = 1'b1;
            act_wdata       = cmd == mat_pkg::CMD_START;
          end else begin
            emit_res.status = mat_pkg::STAT_WRONG_TRAN;
          end
        end else if (at_last) begin
          emit            = 1'b1;
          emit_res.status = mat_pkg::STAT_UNKNOWN_ID;
        end
      end
      mat_pkg::ST_CLOSE: begin
        emit            = 1'b1;
        emit_res.kind   = mat_pkg::KIND_DONE;
        emit_res.status = mat_pkg::STAT_OK;
        emit_res.last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mat_pkg::ST_IDLE;
      slot  <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= command;
      id  <= alarm_id;
    end
    if (emit) begin
      event_kind  <= emit_res.kind;
      slot_index  <= emit_res.slot;
      task_number <= emit_res.task_id;
      status      <= emit_res.status;
      last        <= emit_res.last;
    end
  end

  // slot state; descriptors reset to zero like the rest
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mat_pkg::SLOT_CAP; i++) begin
        desc[i]    <= '0;
        active[i]  <= 1'b0;
        counter[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        desc[cfg_index] <= mat_pkg::desc_t'(cfg_data);
      end
      if (act_we) begin
        active[slot] <= act_wdata;
      end
      if (cnt_we) begin
        counter[slot] <= cnt_wdata;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/mat_checker.sv
// Port-level checks for the multi-alarm tick timer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mat_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       valid,
  input wire logic [2:0] event_kind,
  input wire logic       last
);

  // an accepted command always makes the sequencer busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // idle sequencer never produces a word in the following cycle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !valid)
    else $error("word produced after an idle cycle");

  // closing word is a command-done word, firing words are not
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> event_kind == mat_pkg::KIND_DONE)
    else $error("final word is not command done");

  a_fire_kind: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> event_kind != mat_pkg::KIND_DONE)
    else $error("command done word without last");

  // command words end with the sequencer free
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> !busy)
    else $error("final word while still busy");

endmodule

bind multi_alarm_tick_timer mat_checker u_mat_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .valid     (valid),
  .event_kind(event_kind),
  .last      (last)
);
`default_nettype wire
